>>> sv/fbfl_pkg.sv
`timescale 1ns / 1ps

package fbfl_pkg;

  localparam int unsigned DEF_MAX_BLOCKS = 256;
  localparam int unsigned IDX_CAP        = 256;

  localparam int unsigned BB_W   = 13;
  localparam int unsigned BLK_W  = 9;
  localparam int unsigned GIDX_W = 8;
  localparam int unsigned OFS_W  = 20;
  localparam int unsigned FCNT_W = 9;
  localparam int unsigned CFG_W  = BB_W;

  localparam logic [BB_W-1:0] BB_RESET = 13'd8;
  localparam logic [BB_W-1:0] BB_MIN   = 13'd1;
  localparam logic [BB_W-1:0] BB_MAX   = 13'd4096;
  localparam logic [BLK_W-1:0] BLK_MIN = 9'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_BLOCK_BYTES   = 1'b0;
  localparam logic CFG_BLOCKS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic              opcode;
    logic [GIDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [GIDX_W-1:0] granted_index;
    logic [OFS_W-1:0]  byte_offset;
    logic [FCNT_W-1:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic             restart;
    logic [BB_W-1:0]  block_bytes;
    logic [BLK_W-1:0] blocks_in_use;
  } cfg_t;

  function automatic int unsigned index_limit(int unsigned max_blocks);
    return (max_blocks < IDX_CAP) ? max_blocks : IDX_CAP;
  endfunction

endpackage

>>> sv/fixed_block_free_list_allocator.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                  | Beat
// in      | input     | in_valid_i / in_ready_o    | req_t: opcode, block_index
// out     | output    | out_valid_o / out_ready_i  | rsp_t: status, granted_index,
//         |           |                            |   byte_offset, free_count
// cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// Free stays idle. Allocate then waits in S_POP for the read of the
// head's next link from the registered link RAM; no new beat is taken meanwhile.
// After reset, and after each blocks_in_use write (registered as restart), a chaining
// pass writes link RAM entries 0 to blocks_in_use-1, one entry per cycle; in_ready_o
// stays low from the cycle after the write until the pass ends.
// One registered result slot: a new beat is taken in the cycle the old result leaves.

module fixed_block_free_list_allocator import fbfl_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_data_o
);

  localparam int unsigned INDEX_LIMIT = index_limit(MAX_BLOCKS);
  localparam logic [BLK_W-1:0] BLK_MAX = BLK_W'(INDEX_LIMIT);

  logic [BB_W-1:0]  block_bytes_q, block_bytes_d;
  logic [BLK_W-1:0] blocks_q, blocks_d;
  logic             restart_q, restart_d;
  logic [BB_W-1:0]  bb_raw;
  logic [BLK_W-1:0] blk_raw;
  cfg_t             cfg;

  assign bb_raw  = cfg_data_i[BB_W-1:0];
  assign blk_raw = cfg_data_i[BLK_W-1:0];

  always_comb begin
    block_bytes_d = block_bytes_q;
    blocks_d      = blocks_q;
    restart_d     = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_BYTES: begin
          if (bb_raw < BB_MIN) begin
            block_bytes_d = BB_MIN;
          end else if (bb_raw > BB_MAX) begin
            block_bytes_d = BB_MAX;
          end else begin
            block_bytes_d = bb_raw;
          end
        end
        CFG_BLOCKS_IN_USE: begin
          restart_d = 1'b1;
          if (blk_raw < BLK_MIN) begin
            blocks_d = BLK_MIN;
          end else if (blk_raw > BLK_MAX) begin
            blocks_d = BLK_MAX;
          end else begin
            blocks_d = blk_raw;
          end
        end
        default: begin
          restart_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= BB_RESET;
      blocks_q      <= BLK_MAX;
      restart_q     <= 1'b0;
    end else begin
      block_bytes_q <= block_bytes_d;
      blocks_q      <= blocks_d;
      restart_q     <= restart_d;
    end
  end

  assign cfg.restart       = restart_q;
  assign cfg.block_bytes   = block_bytes_q;
  assign cfg.blocks_in_use = blocks_q;

  fbfl_core #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> sv/fbfl_ram.sv
`timescale 1ns / 1ps

module fbfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/fbfl_core.sv
`timescale 1ns / 1ps

module fbfl_core import fbfl_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned INDEX_LIMIT = index_limit(MAX_BLOCKS);
  localparam int unsigned IDX_W       = $clog2(INDEX_LIMIT);
  localparam int unsigned CNT_W       = $clog2(INDEX_LIMIT + 1);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_POP
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic [CNT_W-1:0]  blocks;
  logic              accept;
  logic              in_range;
  logic [IDX_W-1:0]  free_idx;
  logic [GIDX_W-1:0] granted;
  logic [OFS_W:0]    product;
  logic [CNT_W-1:0]  free_inc;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr, ram_wdata, ram_rdata;

  assign blocks     = CNT_W'(cfg_i.blocks_in_use);
  assign in_ready_o = (state_q == S_IDLE) && !cfg_i.restart &&
                      (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, in_data_i.block_index} < BLK_W'(blocks);
  assign free_idx   = in_data_i.block_index[IDX_W-1:0];
  assign granted    = GIDX_W'(head_q);
  assign product    = (OFS_W+1)'(granted) * (OFS_W+1)'(cfg_i.block_bytes);
  assign free_inc   = (free_q < blocks) ? free_q + 1'b1 : free_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    free_d      = free_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = free_idx;
    ram_wdata   = head_q;
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = (cnt_q == '0) ? '0 : IDX_W'(cnt_q - 1'b1);
        cnt_d     = cnt_q + 1'b1;
        if (CNT_W'(cnt_q) == CNT_W'(blocks - 1'b1)) begin
          head_d  = IDX_W'(blocks - 1'b1);
          free_d  = blocks;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          out_valid_d         = 1'b1;
          out_d.granted_index = '0;
          out_d.byte_offset   = '0;
          if (in_data_i.opcode == OP_ALLOC) begin
            if (free_q == '0) begin
              out_d.status     = ST_EMPTY;
              out_d.free_count = '0;
            end else begin
              ram_re              = 1'b1;
              free_d              = free_q - 1'b1;
              out_d.status        = ST_OK;
              out_d.granted_index = granted;
              out_d.byte_offset   = product[OFS_W-1:0];
              out_d.free_count    = FCNT_W'(free_q - 1'b1);
              state_d             = S_POP;
            end
          end else begin
            if (in_range) begin
              ram_we           = 1'b1;
              head_d           = free_idx;
              free_d           = free_inc;
              out_d.status     = ST_OK;
              out_d.free_count = FCNT_W'(free_inc);
            end else begin
              out_d.status     = ST_RANGE;
              out_d.free_count = FCNT_W'(free_q);
            end
          end
        end
      end
      S_POP: begin
        head_d  = ram_rdata;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
        cnt_d   = '0;
      end
    endcase

    if (cfg_i.restart) begin
      state_d = S_INIT;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      head_q      <= '0;
      free_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  fbfl_ram #(
    .WIDTH(IDX_W),
    .DEPTH(INDEX_LIMIT)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_pop_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.opcode == OP_ALLOC && free_q != '0 && !cfg_i.restart)
      |=> (state_q == S_POP))
    else $error("pop did not enter link read");

  a_no_ram_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("link read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INIT && !cfg_i.restart) |-> (free_q <= blocks))
    else $error("free count above pool size");

  a_head_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !cfg_i.restart) |-> (CNT_W'(head_q) < blocks))
    else $error("head outside pool");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fbfl_pkg::*;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we     = 1'b0;
  logic             cfg_idx    = CFG_BLOCK_BYTES;
  logic [CFG_W-1:0] cfg_data   = '0;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  req_t             in_data    = '0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  rsp_t             out_data;

  fixed_block_free_list_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the pool
  logic [BLK_W-1:0] link_tbl [256];
  logic [BLK_W-1:0] pool_head;
  logic [BLK_W-1:0] pool_free;
  logic [BLK_W-1:0] pool_size;
  logic [BB_W-1:0]  blk_bytes;

  req_t req_todo [$];
  rsp_t rsp_due [$];
  int   live_idx [$];
  int   errors = 0;

  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  rsp_t want;
  rsp_t exp_r;

  function automatic void rechain_pool(logic [BLK_W-1:0] n);
    for (int i = 0; i < 256; i++) begin
      link_tbl[i] = (i > 0 && i < n) ? BLK_W'(i - 1) : '0;
    end
    pool_size = n;
    pool_head = n - 1'b1;
    pool_free = n;
  endfunction

  function automatic rsp_t pool_apply(req_t r);
    rsp_t o;
    logic [GIDX_W-1:0] g;
    o = '0;
    o.status = ST_OK;
    if (r.opcode == OP_ALLOC) begin
      if (pool_free == 0) begin
        o.status = ST_EMPTY;
      end else begin
        g = pool_head[GIDX_W-1:0];
        o.granted_index = g;
        o.byte_offset = OFS_W'(int'(g) * int'(blk_bytes));
        pool_head = link_tbl[g];
        pool_free = pool_free - 1'b1;
      end
    end else if ({1'b0, r.block_index} >= pool_size) begin
      o.status = ST_RANGE;
    end else begin
      link_tbl[r.block_index] = pool_head;
      pool_head = {1'b0, r.block_index};
      if (pool_free < pool_size) pool_free = pool_free + 1'b1;
    end
    o.free_count = pool_free;
    return o;
  endfunction

  // Request driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        want = pool_apply(in_data);
        rsp_due.push_back(want);
        if (in_data.opcode == OP_ALLOC && want.status == ST_OK) begin
          live_idx.push_back(int'(want.granted_index));
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_todo.size() != 0) begin
          in_data  <= req_todo.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(32, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (rsp_due.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
      end else begin
        exp_r = rsp_due.pop_front();
        if (out_data.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_data.status);
          errors++;
        end
        if (out_data.granted_index !== exp_r.granted_index) begin
          $error("granted_index: expected %0d, got %0d",
                 exp_r.granted_index, out_data.granted_index);
          errors++;
        end
        if (out_data.byte_offset !== exp_r.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d",
                 exp_r.byte_offset, out_data.byte_offset);
          errors++;
        end
        if (out_data.free_count !== exp_r.free_count) begin
          $error("free_count: expected %0d, got %0d",
                 exp_r.free_count, out_data.free_count);
          errors++;
        end
      end
    end
  end

  task automatic queue_item(input logic op, input logic [GIDX_W-1:0] idx);
    req_t r;
    @(negedge clk_i);
    while (req_todo.size() >= 3) @(negedge clk_i);
    r.opcode = op;
    r.block_index = idx;
    req_todo.push_back(r);
  endtask

  task automatic drain();
    while (req_todo.size() != 0 || in_valid || rsp_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    logic [BB_W-1:0]  bb;
    logic [BLK_W-1:0] n;
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_BYTES) begin
      bb = val;
      if (bb < BB_MIN) bb = BB_MIN;
      if (bb > BB_MAX) bb = BB_MAX;
      blk_bytes = bb;
    end else begin
      n = val[BLK_W-1:0];
      if (n < BLK_MIN) n = BLK_MIN;
      if (n > 9'd256) n = 9'd256;
      rechain_pool(n);
      live_idx.delete();
    end
  endtask

  task automatic reconfigure(input int bb, input int biu);
    drain();
    write_reg(CFG_BLOCK_BYTES, CFG_W'(bb));
    write_reg(CFG_BLOCKS_IN_USE, CFG_W'(biu));
  endtask

  task automatic random_run(input int n);
    int alloc_pct;
    int k;
    alloc_pct = $urandom_range(25, 75);
    repeat (n) begin
      if ($urandom_range(0, 249) == 0) drain();
      if ($urandom_range(0, 99) < 10) begin
        queue_item(OP_FREE, GIDX_W'($urandom_range(0, 255)));
      end else if (live_idx.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
        queue_item(OP_ALLOC, GIDX_W'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(0, live_idx.size() - 1);
        queue_item(OP_FREE, GIDX_W'(live_idx[k]));
        live_idx.delete(k);
      end
    end
  endtask

  initial begin
    blk_bytes = BB_RESET;
    rechain_pool(9'd256);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: top of the list first, highest free index
    queue_item(OP_ALLOC, 8'd0);
    queue_item(OP_ALLOC, 8'd255);
    queue_item(OP_FREE, 8'd254);
    queue_item(OP_FREE, 8'd255);
    queue_item(OP_ALLOC, 8'd0);
    queue_item(OP_FREE, 8'd255);
    random_run(180);

    reconfigure(4096, 256);
    random_run(180);

    // tiny pool: empty, out of range, double free, saturation
    reconfigure(0, 4);
    repeat (5) queue_item(OP_ALLOC, 8'd0);
    queue_item(OP_FREE, 8'd255);
    queue_item(OP_FREE, 8'd4);
    queue_item(OP_FREE, 8'd3);
    queue_item(OP_FREE, 8'd3);
    queue_item(OP_FREE, 8'd0);
    queue_item(OP_FREE, 8'd1);
    queue_item(OP_FREE, 8'd2);
    queue_item(OP_FREE, 8'd2);
    queue_item(OP_ALLOC, 8'd0);
    queue_item(OP_ALLOC, 8'd0);
    random_run(150);

    reconfigure(8191, 0);
    random_run(80);
    reconfigure(1, 511);
    random_run(180);
    reconfigure(4096, 1);
    random_run(80);

    repeat (7) begin
      reconfigure($urandom_range(0, 8191),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(1, 24));
      random_run(100);
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
